### src/psc_pkg.sv
// Package for the polygon scanline crossings core.
// Holds shared constants, request codes and the controller/datapath structs.
// No dependencies.
package psc_pkg;

   // Default sizing handed to the top level parameters
   localparam int unsigned MAX_VERTICES_DEF = 32;
   localparam int unsigned COORD_BITS_DEF   = 32;

   // Port field widths
   localparam int unsigned FIELD_W = 32;
   localparam int unsigned IDX_W   = 6;

   // Result buffer sizing
   localparam int unsigned RES_CAP = 64;
   localparam int unsigned RES_AW  = 6;
   localparam int unsigned RES_CW  = 7;

   // Request codes
   localparam logic REQ_APPEND = 1'b0;
   localparam logic REQ_QUERY  = 1'b1;

   // Commands from the controller to the datapath
   typedef struct packed {
      logic append;
      logic query_init;
      logic rd_first;
      logic cap_first;
      logic rd_next;
      logic cap_next;
      logic push1;
      logic push2;
      logic cross_go;
      logic push_cross;
      logic advance;
      logic out_init;
      logic emit_empty;
      logic ord_rd;
      logic ord_emit;
      logic scan_step;
      logic sel_emit;
   } cmd_type;

   // Status from the datapath to the controller
   typedef struct packed {
      logic total_zero;
      logic walk_last;
      logic between;
      logic md_done;
      logic none;
      logic sort_mode;
      logic scan_end;
      logic out_last;
   } status_type;

endpackage

### src/psc_ram.sv
// Generic single write port, single read port RAM with registered read.
// No dependencies.
module psc_ram #(
   parameter int unsigned WIDTH  = 8,
   parameter int unsigned DEPTH  = 2,
   parameter int unsigned ADDR_W = 1
) (
   input  logic              clock,
   input  logic              we,
   input  logic [ADDR_W-1:0] waddr,
   input  logic [WIDTH-1:0]  wdata,
   input  logic [ADDR_W-1:0] raddr,
   output logic [WIDTH-1:0]  rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   // Write one entry, read one entry
   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

### src/psc_muldiv.sv
// Serial unit for the crossing offset: round(a*b / d), one bit per cycle.
// Shift-add multiply, then restoring divide of the double-width product.
// No dependencies.
module psc_muldiv #(
   parameter int unsigned DW = 33
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          start,
   input  logic [DW-1:0] a,
   input  logic [DW-1:0] b,
   input  logic [DW-1:0] d,
   output logic          done,
   output logic [DW-1:0] q
);

   localparam int unsigned NW    = 2 * DW;
   localparam int unsigned CNT_W = $clog2(NW);

   localparam logic [1:0] PH_IDLE = 2'd0;
   localparam logic [1:0] PH_MUL  = 2'd1;
   localparam logic [1:0] PH_DIV  = 2'd2;

   logic [1:0]       phase_ff, phase_in;
   logic             done_ff, done_in;
   logic [CNT_W-1:0] cnt_ff;
   logic [NW-1:0]    acc_ff;
   logic [NW-1:0]    ash_ff;
   logic [DW-1:0]    b_ff;
   logic [DW-1:0]    d_ff;
   logic [DW-1:0]    rem_ff;
   logic [DW-1:0]    q_ff;
   logic [DW:0]      rem_sh;
   logic [DW:0]      rem_sub;
   logic             fits;
   logic             mul_last;
   logic             div_last;

   assign rem_sh   = {rem_ff, acc_ff[NW-1]};
   assign rem_sub  = rem_sh - {1'b0, d_ff};
   assign fits     = rem_sh >= {1'b0, d_ff};
   assign mul_last = cnt_ff == CNT_W'(DW - 1);
   assign div_last = cnt_ff == CNT_W'(NW - 1);

   // Phase sequencing
   always_comb begin
      phase_in = phase_ff;
      done_in  = 1'b0;
      unique case (phase_ff)
         PH_IDLE: begin
            if (start) begin
               phase_in = PH_MUL;
            end
         end
         PH_MUL: begin
            if (mul_last) begin
               phase_in = PH_DIV;
            end
         end
         PH_DIV: begin
            if (div_last) begin
               phase_in = PH_IDLE;
               done_in  = 1'b1;
            end
         end
         default: phase_in = PH_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
         done_ff  <= 1'b0;
      end else begin
         phase_ff <= phase_in;
         done_ff  <= done_in;
      end
   end

   // Accumulate the product with the rounding half, then divide it down
   always_ff @(posedge clock) begin
      case (phase_ff)
         PH_IDLE: begin
            if (start) begin
               acc_ff <= NW'(d >> 1);
               ash_ff <= NW'(a);
               b_ff   <= b;
               d_ff   <= d;
               cnt_ff <= '0;
            end
         end
         PH_MUL: begin
            if (b_ff[0]) begin
               acc_ff <= acc_ff + ash_ff;
            end
            ash_ff <= ash_ff << 1;
            b_ff   <= b_ff >> 1;
            cnt_ff <= mul_last ? '0 : cnt_ff + 1'b1;
            rem_ff <= '0;
            q_ff   <= '0;
         end
         PH_DIV: begin
            rem_ff <= fits ? rem_sub[DW-1:0] : rem_sh[DW-1:0];
            q_ff   <= {q_ff[DW-2:0], fits};
            acc_ff <= acc_ff << 1;
            cnt_ff <= cnt_ff + 1'b1;
         end
         default: ;
      endcase
   end

   assign done = done_ff;
   assign q    = q_ff;

endmodule

### src/psc_datapath.sv
// Datapath: vertex store, edge walk registers, crossing unit, result buffer,
// stable selection for sorted output and the result registers.
// Depends on psc_pkg, psc_ram and psc_muldiv.
module psc_datapath #(
   parameter int unsigned MAX_VERTICES = 32,
   parameter int unsigned COORD_BITS   = 32
) (
   input  logic                          clock,
   input  logic                          reset,
   input  psc_pkg::cmd_type              cmd,
   output psc_pkg::status_type           status,
   input  logic                          req_start_new,
   input  logic [psc_pkg::FIELD_W-1:0]   req_vertex_x,
   input  logic [psc_pkg::FIELD_W-1:0]   req_vertex_y,
   input  logic [psc_pkg::FIELD_W-1:0]   req_query_y,
   input  logic                          csr_we,
   input  logic                          csr_wdata,
   output logic                          rsp_valid,
   output logic [psc_pkg::FIELD_W-1:0]   rsp_x_value,
   output logic [psc_pkg::IDX_W-1:0]     rsp_point_index,
   output logic                          rsp_empty_res,
   output logic                          rsp_overflow,
   output logic                          rsp_last
);
   import psc_pkg::*;

   localparam int unsigned CW  = COORD_BITS;
   localparam int unsigned DW  = CW + 1;
   localparam int unsigned VIW = $clog2(MAX_VERTICES + 1);
   localparam int unsigned AW  = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
   localparam int unsigned RW  = CW + IDX_W;

   // Vertex count, overflow and mode
   logic [VIW-1:0] total_ff;
   logic           ovf_ff;
   logic           sort_ff;
   logic [VIW-1:0] base;
   logic           can_add;

   // Edge walk
   logic signed [CW-1:0] qy_ff;
   logic [VIW-1:0]       i_ff;
   logic [VIW-1:0]       inext;
   logic [2*CW-1:0]      first_ff;
   logic signed [CW-1:0] x1_ff, y1_ff, x2_ff, y2_ff;
   logic [2*CW-1:0]      vtx_rdata;
   logic [AW-1:0]        vtx_raddr;
   logic [VIW+IDX_W-1:0] idx_i_ext, idx_n_ext;
   logic                 hit1, hit2;

   // Crossing
   logic signed [CW:0]   dx, dy, dq;
   logic [DW-1:0]        a_abs, b_abs, d_abs;
   logic                 dxneg_ff;
   logic                 md_done;
   logic [DW-1:0]        md_q;
   logic signed [CW-1:0] cross_x;

   // Result buffer
   logic [RES_CW-1:0] nres_ff;
   logic              push_en;
   logic [RW-1:0]     push_data;
   logic [RES_AW-1:0] res_raddr;
   logic [RW-1:0]     res_rdata;

   // Output ordering
   logic [RES_CW-1:0]    k_ff, s_ff;
   logic                 rd_vld_ff;
   logic [RES_CW-1:0]    rd_pos_ff;
   logic                 have_last_ff, found_ff;
   logic signed [CW-1:0] lx_ff, bx_ff;
   logic [RES_CW-1:0]    lpos_ff, bpos_ff;
   logic [IDX_W-1:0]     bidx_ff;
   logic signed [CW-1:0] rx;
   logic [IDX_W-1:0]     ridx;
   logic                 cand_ok, better;

   // Result registers
   logic                 rsp_valid_ff;
   logic [FIELD_W-1:0]   rsp_x_ff;
   logic [IDX_W-1:0]     rsp_idx_ff;
   logic                 rsp_empty_ff, rsp_last_ff;
   logic [CW+FIELD_W-1:0] x_in_ext, y_in_ext, q_in_ext;
   logic [CW+FIELD_W-1:0] emit_x_ext;
   logic signed [CW-1:0]  emit_x;

   // Fit the port coordinates to the internal width
   assign x_in_ext = {{CW{1'b0}}, req_vertex_x};
   assign y_in_ext = {{CW{1'b0}}, req_vertex_y};
   assign q_in_ext = {{CW{1'b0}}, req_query_y};

   // Append target slot
   assign base    = req_start_new ? '0 : total_ff;
   assign can_add = base < VIW'(MAX_VERTICES);

   psc_ram #(
      .WIDTH  (2 * CW),
      .DEPTH  (MAX_VERTICES),
      .ADDR_W (AW)
   ) u_vtx_ram (
      .clock (clock),
      .we    (cmd.append && can_add),
      .waddr (base[AW-1:0]),
      .wdata ({x_in_ext[CW-1:0], y_in_ext[CW-1:0]}),
      .raddr (vtx_raddr),
      .rdata (vtx_rdata)
   );

   // Vertex count, overflow and the mode register
   always_ff @(posedge clock) begin
      if (reset) begin
         total_ff <= '0;
         ovf_ff   <= 1'b0;
         sort_ff  <= 1'b1;
      end else begin
         if (cmd.append) begin
            total_ff <= can_add ? base + 1'b1 : base;
            ovf_ff   <= (req_start_new ? 1'b0 : ovf_ff) | ~can_add;
         end
         if (csr_we) begin
            sort_ff <= csr_wdata;
         end
      end
   end

   // Edge geometry
   assign inext     = i_ff + 1'b1;
   assign vtx_raddr = cmd.rd_first ? '0 : inext[AW-1:0];
   assign idx_i_ext = {{IDX_W{1'b0}}, i_ff};
   assign idx_n_ext = {{IDX_W{1'b0}}, inext};
   assign hit1      = y1_ff == qy_ff;
   assign hit2      = y2_ff == qy_ff;
   assign dx        = {x2_ff[CW-1], x2_ff} - {x1_ff[CW-1], x1_ff};
   assign dq        = {qy_ff[CW-1], qy_ff} - {y1_ff[CW-1], y1_ff};
   assign dy        = {y2_ff[CW-1], y2_ff} - {y1_ff[CW-1], y1_ff};
   assign a_abs     = dx[CW] ? ~dx + 1'b1 : dx;
   assign b_abs     = dq[CW] ? ~dq + 1'b1 : dq;
   assign d_abs     = dy[CW] ? ~dy + 1'b1 : dy;

   // Walk the edges, carrying the second endpoint over as the next first
   always_ff @(posedge clock) begin
      if (cmd.query_init) begin
         qy_ff <= q_in_ext[CW-1:0];
         i_ff  <= '0;
      end
      if (cmd.cap_first) begin
         first_ff <= vtx_rdata;
         x1_ff    <= vtx_rdata[2*CW-1:CW];
         y1_ff    <= vtx_rdata[CW-1:0];
      end
      if (cmd.cap_next) begin
         if (inext == total_ff) begin
            x2_ff <= first_ff[2*CW-1:CW];
            y2_ff <= first_ff[CW-1:0];
         end else begin
            x2_ff <= vtx_rdata[2*CW-1:CW];
            y2_ff <= vtx_rdata[CW-1:0];
         end
      end
      if (cmd.cross_go) begin
         dxneg_ff <= dx[CW];
      end
      if (cmd.advance) begin
         x1_ff <= x2_ff;
         y1_ff <= y2_ff;
         i_ff  <= inext;
      end
   end

   psc_muldiv #(
      .DW (DW)
   ) u_muldiv (
      .clock (clock),
      .reset (reset),
      .start (cmd.cross_go),
      .a     (a_abs),
      .b     (b_abs),
      .d     (d_abs),
      .done  (md_done),
      .q     (md_q)
   );

   assign cross_x = dxneg_ff ? x1_ff - md_q[CW-1:0] : x1_ff + md_q[CW-1:0];

   // Push hits into the result buffer, first results win when full
   always_comb begin
      if (cmd.push1) begin
         push_data = {x1_ff, idx_i_ext[IDX_W-1:0]};
      end else if (cmd.push2) begin
         push_data = {x2_ff, idx_n_ext[IDX_W-1:0]};
      end else begin
         push_data = {cross_x, idx_i_ext[IDX_W-1:0]};
      end
   end

   assign push_en = ((cmd.push1 && hit1) || (cmd.push2 && hit2) ||
                     (cmd.push_cross && md_done)) && (nres_ff < RES_CW'(RES_CAP));

   always_ff @(posedge clock) begin
      if (cmd.query_init) begin
         nres_ff <= '0;
      end else if (push_en) begin
         nres_ff <= nres_ff + 1'b1;
      end
   end

   assign res_raddr = cmd.ord_rd ? k_ff[RES_AW-1:0] : s_ff[RES_AW-1:0];

   psc_ram #(
      .WIDTH  (RW),
      .DEPTH  (RES_CAP),
      .ADDR_W (RES_AW)
   ) u_res_ram (
      .clock (clock),
      .we    (push_en),
      .waddr (nres_ff[RES_AW-1:0]),
      .wdata (push_data),
      .raddr (res_raddr),
      .rdata (res_rdata)
   );

   // Stable selection: smallest entry after the last one sent, by (x, position)
   assign rx      = res_rdata[RW-1:IDX_W];
   assign ridx    = res_rdata[IDX_W-1:0];
   assign cand_ok = !have_last_ff || (rx > lx_ff) || ((rx == lx_ff) && (rd_pos_ff > lpos_ff));
   assign better  = !found_ff || (rx < bx_ff);

   always_ff @(posedge clock) begin
      rd_vld_ff <= cmd.scan_step;
      rd_pos_ff <= s_ff;
      if (cmd.out_init) begin
         k_ff         <= '0;
         s_ff         <= '0;
         have_last_ff <= 1'b0;
         found_ff     <= 1'b0;
      end else begin
         if (cmd.scan_step) begin
            s_ff <= s_ff + 1'b1;
         end
         if (rd_vld_ff && cand_ok && better) begin
            bx_ff    <= rx;
            bidx_ff  <= ridx;
            bpos_ff  <= rd_pos_ff;
            found_ff <= 1'b1;
         end
         if (cmd.sel_emit) begin
            lx_ff        <= bx_ff;
            lpos_ff      <= bpos_ff;
            have_last_ff <= 1'b1;
            found_ff     <= 1'b0;
            s_ff         <= '0;
         end
         if (cmd.sel_emit || cmd.ord_emit) begin
            k_ff <= k_ff + 1'b1;
         end
      end
   end

   // Drive the result beat
   assign emit_x     = cmd.sel_emit ? bx_ff : rx;
   assign emit_x_ext = {{FIELD_W{emit_x[CW-1]}}, emit_x};

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= cmd.emit_empty || cmd.ord_emit || cmd.sel_emit;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit_empty) begin
         rsp_x_ff     <= '0;
         rsp_idx_ff   <= '0;
         rsp_empty_ff <= 1'b1;
         rsp_last_ff  <= 1'b1;
      end else begin
         rsp_x_ff     <= emit_x_ext[FIELD_W-1:0];
         rsp_idx_ff   <= cmd.sel_emit ? bidx_ff : ridx;
         rsp_empty_ff <= 1'b0;
         rsp_last_ff  <= status.out_last;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_x_value     = rsp_x_ff;
   assign rsp_point_index = rsp_idx_ff;
   assign rsp_empty_res   = rsp_empty_ff;
   assign rsp_overflow    = ovf_ff;
   assign rsp_last        = rsp_last_ff;

   // Status to the controller
   assign status.total_zero = total_ff == '0;
   assign status.walk_last  = inext == total_ff;
   assign status.between    = ((y1_ff < qy_ff) && (qy_ff < y2_ff)) ||
                              ((y2_ff < qy_ff) && (qy_ff < y1_ff));
   assign status.md_done    = md_done;
   assign status.none       = nres_ff == '0;
   assign status.sort_mode  = sort_ff;
   assign status.scan_end   = (s_ff + 1'b1) == nres_ff;
   assign status.out_last   = (k_ff + 1'b1) == nres_ff;

endmodule

### src/psc_ctrl.sv
// Controller: sequences append, edge walk, crossing wait and output phases.
// Depends on psc_pkg.
module psc_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   input  logic                req_type,
   input  psc_pkg::status_type status,
   output psc_pkg::cmd_type    cmd,
   output logic                busy
);
   import psc_pkg::*;

   localparam logic [4:0] S_IDLE   = 5'd0;
   localparam logic [4:0] S_RD0    = 5'd1;
   localparam logic [4:0] S_CAP0   = 5'd2;
   localparam logic [4:0] S_RDN    = 5'd3;
   localparam logic [4:0] S_CAPN   = 5'd4;
   localparam logic [4:0] S_HIT1   = 5'd5;
   localparam logic [4:0] S_HIT2   = 5'd6;
   localparam logic [4:0] S_CROSS  = 5'd7;
   localparam logic [4:0] S_MD     = 5'd8;
   localparam logic [4:0] S_NEXT   = 5'd9;
   localparam logic [4:0] S_OUTSEL = 5'd10;
   localparam logic [4:0] S_EMPTY  = 5'd11;
   localparam logic [4:0] S_ORD    = 5'd12;
   localparam logic [4:0] S_ORDE   = 5'd13;
   localparam logic [4:0] S_SCAN   = 5'd14;
   localparam logic [4:0] S_DRAIN  = 5'd15;
   localparam logic [4:0] S_SEL    = 5'd16;

   logic [4:0] state_ff, state_in;

   // Next state and commands
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               if (req_type == REQ_QUERY) begin
                  cmd.query_init = 1'b1;
                  state_in       = status.total_zero ? S_EMPTY : S_RD0;
               end else begin
                  cmd.append = 1'b1;
               end
            end
         end
         S_RD0: begin
            cmd.rd_first = 1'b1;
            state_in     = S_CAP0;
         end
         S_CAP0: begin
            cmd.cap_first = 1'b1;
            state_in      = S_RDN;
         end
         S_RDN: begin
            cmd.rd_next = 1'b1;
            state_in    = S_CAPN;
         end
         S_CAPN: begin
            cmd.cap_next = 1'b1;
            state_in     = S_HIT1;
         end
         S_HIT1: begin
            cmd.push1 = 1'b1;
            state_in  = S_HIT2;
         end
         S_HIT2: begin
            cmd.push2 = 1'b1;
            state_in  = S_CROSS;
         end
         S_CROSS: begin
            if (status.between) begin
               cmd.cross_go = 1'b1;
               state_in     = S_MD;
            end else begin
               state_in = S_NEXT;
            end
         end
         S_MD: begin
            if (status.md_done) begin
               cmd.push_cross = 1'b1;
               state_in       = S_NEXT;
            end
         end
         S_NEXT: begin
            cmd.advance = 1'b1;
            state_in    = status.walk_last ? S_OUTSEL : S_RDN;
         end
         S_OUTSEL: begin
            cmd.out_init = 1'b1;
            if (status.none) begin
               state_in = S_EMPTY;
            end else if (status.sort_mode) begin
               state_in = S_SCAN;
            end else begin
               state_in = S_ORD;
            end
         end
         S_EMPTY: begin
            cmd.emit_empty = 1'b1;
            state_in       = S_IDLE;
         end
         S_ORD: begin
            cmd.ord_rd = 1'b1;
            state_in   = S_ORDE;
         end
         S_ORDE: begin
            cmd.ord_emit = 1'b1;
            state_in     = status.out_last ? S_IDLE : S_ORD;
         end
         S_SCAN: begin
            cmd.scan_step = 1'b1;
            if (status.scan_end) begin
               state_in = S_DRAIN;
            end
         end
         S_DRAIN: begin
            state_in = S_SEL;
         end
         S_SEL: begin
            cmd.sel_emit = 1'b1;
            state_in     = status.out_last ? S_IDLE : S_SCAN;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign busy = state_ff != S_IDLE;

endmodule

### src/polygon_scanline_crossings_core.sv
// Polygon scanline crossings core. An append is taken in the idle state and busy stays low.
// A query first reads and captures vertex 0, then for each edge reads and captures the next
// vertex, checks both endpoints for hits and runs the serial multiply/divide unit on a
// crossing, then emits the results sorted by a selection scan over the result RAM, or unsorted.
// Each beat shows in the cycle after its slot; the receiver cannot stall. Synchronous reset
// clears control, the vertex count, overflow, and sets sort_by_x; no memory clearing pass.
module polygon_scanline_crossings_core #(
   parameter int unsigned MAX_VERTICES = psc_pkg::MAX_VERTICES_DEF,
   parameter int unsigned COORD_BITS   = psc_pkg::COORD_BITS_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   output logic                        busy,
   input  logic                        req_type,
   input  logic                        req_start_new,
   input  logic [psc_pkg::FIELD_W-1:0] req_vertex_x,
   input  logic [psc_pkg::FIELD_W-1:0] req_vertex_y,
   input  logic [psc_pkg::FIELD_W-1:0] req_query_y,
   input  logic                        csr_we,
   input  logic                        csr_wdata,
   output logic                        rsp_valid,
   output logic [psc_pkg::FIELD_W-1:0] rsp_x_value,
   output logic [psc_pkg::IDX_W-1:0]   rsp_point_index,
   output logic                        rsp_empty_res,
   output logic                        rsp_overflow,
   output logic                        rsp_last
);
   import psc_pkg::*;

   cmd_type    cmd;
   status_type status;

   psc_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .req_type (req_type),
      .status   (status),
      .cmd      (cmd),
      .busy     (busy)
   );

   psc_datapath #(
      .MAX_VERTICES (MAX_VERTICES),
      .COORD_BITS   (COORD_BITS)
   ) u_datapath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .status          (status),
      .req_start_new   (req_start_new),
      .req_vertex_x    (req_vertex_x),
      .req_vertex_y    (req_vertex_y),
      .req_query_y     (req_query_y),
      .csr_we          (csr_we),
      .csr_wdata       (csr_wdata),
      .rsp_valid       (rsp_valid),
      .rsp_x_value     (rsp_x_value),
      .rsp_point_index (rsp_point_index),
      .rsp_empty_res   (rsp_empty_res),
      .rsp_overflow    (rsp_overflow),
      .rsp_last        (rsp_last)
   );

endmodule

### src/psc_checker.sv
// Port-level checker for the polygon scanline crossings core, bound to the top.
// Depends on psc_pkg and polygon_scanline_crossings_core.
module psc_checker (
   input logic                        clock,
   input logic                        reset,
   input logic                        start,
   input logic                        busy,
   input logic                        req_type,
   input logic                        rsp_valid,
   input logic [psc_pkg::FIELD_W-1:0] rsp_x_value,
   input logic [psc_pkg::IDX_W-1:0]   rsp_point_index,
   input logic                        rsp_empty_res,
   input logic                        rsp_last
);
   import psc_pkg::*;

   // A result beat only comes right after a busy cycle
   a_beat_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(busy)) else $error("result beat while idle");

   // An accepted query holds busy on the next cycle
   a_query_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && req_type == REQ_QUERY) |=> busy)
      else $error("query accepted but busy low");

   // An empty beat is the only and last beat, with zero fields
   a_empty_form: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_empty_res) |->
      (rsp_last && rsp_x_value == '0 && rsp_point_index == '0))
      else $error("malformed empty beat");

   // No beat follows the last beat of a query
   a_last_end: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_last) |=> !rsp_valid) else $error("beat after last");

   // Busy drops together with the last beat
   a_busy_end: assert property (@(posedge clock) disable iff (reset)
      $fell(busy) |-> (rsp_valid && rsp_last))
      else $error("query ended without last beat");

endmodule

bind polygon_scanline_crossings_core psc_checker u_psc_checker (
   .clock           (clock),
   .reset           (reset),
   .start           (start),
   .busy            (busy),
   .req_type        (req_type),
   .rsp_valid       (rsp_valid),
   .rsp_x_value     (rsp_x_value),
   .rsp_point_index (rsp_point_index),
   .rsp_empty_res   (rsp_empty_res),
   .rsp_last        (rsp_last)
);
